[design/lwpf_pkg.sv]
// Package for the LCD window and pixel formatter: opcodes, link frame codes,
// item record and frame types, and the frame selection functions.
// No dependencies.
package lwpf_pkg;

  // Screen dimensions (defaults for the top level parameters)
  localparam int LWPF_LONG_SIDE  = 480;
  localparam int LWPF_SHORT_SIDE = 320;

  // Coordinates hold up to 4095; sums of a coordinate and a 9-bit size need one more bit
  localparam int COORD_W = 12;
  localparam int SUM_W   = 13;
  localparam int IDX_W   = 4;

  typedef enum logic [1:0] {
    OP_WINDOW = 2'd0,
    OP_RAW    = 2'd1,
    OP_RGB    = 2'd2,
    OP_ROT    = 2'd3
  } op_t;

  localparam logic [7:0] PFX_CMD     = 8'h11;
  localparam logic [7:0] PFX_DAT     = 8'h15;
  localparam logic [7:0] CMD_COL_SET = 8'h2A;
  localparam logic [7:0] CMD_PAG_SET = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR  = 8'h2C;
  localparam logic [7:0] CMD_MADCTL  = 8'h36;

  localparam logic [7:0] ORIENT_0   = 8'b11101010;
  localparam logic [7:0] ORIENT_90  = 8'b01001010;
  localparam logic [7:0] ORIENT_180 = 8'b00101010;
  localparam logic [7:0] ORIENT_270 = 8'h8A;

  // Index of the final frame of each item kind
  localparam logic [IDX_W-1:0] LAST_IDX_WIN = IDX_W'(10);
  localparam logic [IDX_W-1:0] LAST_IDX_ROT = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX_PIX = IDX_W'(0);

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [15:0]        color;
    logic [7:0]         orient;
  } item_rec_t;

  typedef struct packed {
    logic [7:0] prefix;
    logic [7:0] high;
    logic [7:0] low;
    logic       last;
  } frame_t;

  typedef struct packed {
    logic             busy;
    logic             at_last;
    logic [IDX_W-1:0] idx;
  } seq_status_t;

  function automatic logic [7:0] orient_byte(input logic [1:0] rot);
    logic [7:0] b;
    case (rot)
      2'd0:    b = ORIENT_0;
      2'd1:    b = ORIENT_90;
      2'd2:    b = ORIENT_180;
      default: b = ORIENT_270;
    endcase
    return b;
  endfunction

  function automatic logic [IDX_W-1:0] last_idx(input op_t op);
    logic [IDX_W-1:0] n;
    case (op)
      OP_WINDOW: n = LAST_IDX_WIN;
      OP_ROT:    n = LAST_IDX_ROT;
      default:   n = LAST_IDX_PIX;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hi_byte(input logic [COORD_W-1:0] v);
    return 8'(v >> 8);
  endfunction

  function automatic frame_t frame_sel(input item_rec_t rec, input logic [IDX_W-1:0] idx);
    frame_t f;
    f.prefix = PFX_DAT;
    f.high   = 8'h00;
    f.low    = 8'h00;
    f.last   = 1'b0;
    case (rec.op)
      OP_WINDOW: begin
        case (idx)
          4'd0:    begin f.prefix = PFX_CMD; f.low = CMD_COL_SET; end
          4'd1:    f.low = hi_byte(rec.x0);
          4'd2:    f.low = rec.x0[7:0];
          4'd3:    f.low = hi_byte(rec.x1);
          4'd4:    f.low = rec.x1[7:0];
          4'd5:    begin f.prefix = PFX_CMD; f.low = CMD_PAG_SET; end
          4'd6:    f.low = hi_byte(rec.y0);
          4'd7:    f.low = rec.y0[7:0];
          4'd8:    f.low = hi_byte(rec.y1);
          4'd9:    f.low = rec.y1[7:0];
          default: begin f.prefix = PFX_CMD; f.low = CMD_MEM_WR; f.last = 1'b1; end
        endcase
      end
      OP_ROT: begin
        if (idx == LAST_IDX_PIX) begin
          f.prefix = PFX_CMD;
          f.low    = CMD_MADCTL;
        end else begin
          f.low  = rec.orient;
          f.last = 1'b1;
        end
      end
      default: begin
        f.high = rec.color[15:8];
        f.low  = rec.color[7:0];
        f.last = 1'b1;
      end
    endcase
    return f;
  endfunction

endpackage

[design/lwpf_in_if.sv]
// Input channel of the LCD formatter: valid/ready plus the item fields.
// No dependencies.
interface lwpf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [8:0] win_x;
  logic [8:0] win_y;
  logic [8:0] win_width;
  logic [8:0] win_height;
  logic [15:0] pixel_565;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] rotation;

  modport source(output valid, opcode, win_x, win_y, win_width, win_height, pixel_565,
                 red, green, blue, rotation, input ready);
  modport sink(input valid, opcode, win_x, win_y, win_width, win_height, pixel_565,
               red, green, blue, rotation, output ready);
endinterface

[design/lwpf_out_if.sv]
// Result channel of the LCD formatter: valid/ready plus one link frame.
// No dependencies.
interface lwpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_prefix;
  logic [7:0] frame_high;
  logic [7:0] frame_low;
  logic       last_frame;

  modport source(output valid, frame_prefix, frame_high, frame_low, last_frame,
                 input ready);
  modport sink(input valid, frame_prefix, frame_high, frame_low, last_frame,
               output ready);
endinterface

[design/lwpf_prep.sv]
// Item preparation: window clipping and flip, RGB565 packing, orientation
// byte, and the sideways orientation flag. Depends on lwpf_pkg.
module lwpf_prep import lwpf_pkg::*; #(
  parameter int LONG_SIDE  = LWPF_LONG_SIDE,
  parameter int SHORT_SIDE = LWPF_SHORT_SIDE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [1:0]  opcode,
  input  logic [8:0]  win_x,
  input  logic [8:0]  win_y,
  input  logic [8:0]  win_width,
  input  logic [8:0]  win_height,
  input  logic [15:0] pixel_565,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [1:0]  rotation,
  output item_rec_t   rec
);

  localparam logic [SUM_W-1:0] LONG_V  = SUM_W'(LONG_SIDE);
  localparam logic [SUM_W-1:0] SHORT_V = SUM_W'(SHORT_SIDE);

  logic             sideways_r;
  logic             sideways_nxt;
  op_t              op;
  logic [SUM_W-1:0] scr_w, scr_h;
  logic [SUM_W-1:0] x_in, y_in, w_in, h_in;
  logic [SUM_W-1:0] xc, yc, xs, ys, xend, yend;

  assign op = op_t'(opcode);

  always_comb begin
    sideways_nxt = sideways_r;
    if (take && op == OP_ROT) sideways_nxt = rotation[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sideways_r <= 1'b0;
    else        sideways_r <= sideways_nxt;
  end

  always_comb begin
    scr_w = sideways_r ? SHORT_V : LONG_V;
    scr_h = sideways_r ? LONG_V : SHORT_V;
    x_in  = SUM_W'(win_x);
    y_in  = SUM_W'(win_y);
    w_in  = (win_width == 9'd0) ? SUM_W'(1) : SUM_W'(win_width);
    h_in  = (win_height == 9'd0) ? SUM_W'(1) : SUM_W'(win_height);
    // clamp the origin onto the screen, then clip the far edge
    xc    = (x_in > scr_w - SUM_W'(1)) ? scr_w - SUM_W'(1) : x_in;
    yc    = (y_in > scr_h - SUM_W'(1)) ? scr_h - SUM_W'(1) : y_in;
    xs    = xc + w_in;
    ys    = yc + h_in;
    xend  = (xs > scr_w) ? scr_w : xs;
    yend  = (ys > scr_h) ? scr_h : ys;
  end

  always_comb begin
    rec.op     = op;
    rec.x0     = COORD_W'(xc);
    rec.x1     = COORD_W'(xend - SUM_W'(1));
    // rows flip to a top-left origin
    rec.y0     = COORD_W'(scr_h - yend);
    rec.y1     = COORD_W'(scr_h - SUM_W'(1) - yc);
    rec.color  = (op == OP_RGB) ? {red[7:3], green[7:2], blue[7:3]} : pixel_565;
    rec.orient = orient_byte(rotation);
  end

endmodule

[design/lwpf_seq.sv]
// Item record register, frame counter and output frame register.
// Steps through the frames of each item. Depends on lwpf_pkg.
module lwpf_seq import lwpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_rec_t   rec_in,
  output logic        out_valid,
  input  logic        out_ready,
  output frame_t      frame,
  output seq_status_t status
);

  item_rec_t        rec_r;
  logic             rec_valid_r, rec_valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  frame_t           frame_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free, emit, at_last, take;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = rec_valid_r && out_free;
  assign at_last  = (idx_r == last_idx(rec_r.op));
  assign in_ready = !rec_valid_r || (emit && at_last);
  assign take     = in_valid && in_ready;

  always_comb begin
    rec_valid_nxt = rec_valid_r;
    idx_nxt       = idx_r;
    if (take) begin
      rec_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (emit) begin
      if (at_last) rec_valid_nxt = 1'b0;
      else         idx_nxt = idx_r + IDX_W'(1);
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rec_r   <= rec_in;
    if (emit) frame_r <= frame_sel(rec_r, idx_r);
  end

  assign out_valid      = out_valid_r;
  assign frame          = frame_r;
  assign status.busy    = rec_valid_r;
  assign status.at_last = at_last;
  assign status.idx     = idx_r;

endmodule

[design/lcd_window_and_pixel_formatter_unit.sv]
// LCD window and pixel formatter top level. Items are held in the item record
// register; frames leave through the output frame register. Throughput: one
// frame per cycle while out_ch.ready allows; pixel items stream one per cycle
// likewise; the frame counter walks 11 frames per window item, 2 per rotation.
// Reset (synchronous, rst_n low) empties both registers and selects landscape.
module lcd_window_and_pixel_formatter_unit import lwpf_pkg::*; #(
  parameter int LONG_SIDE  = LWPF_LONG_SIDE,
  parameter int SHORT_SIDE = LWPF_SHORT_SIDE
) (
  input  logic        clk,
  input  logic        rst_n,
  lwpf_in_if.sink     in_ch,
  lwpf_out_if.source  out_ch
);

  item_rec_t   rec;
  frame_t      frame;
  seq_status_t status;
  logic        take;

  assign take = in_ch.valid && in_ch.ready;

  lwpf_prep #(
    .LONG_SIDE  (LONG_SIDE),
    .SHORT_SIDE (SHORT_SIDE)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .opcode     (in_ch.opcode),
    .win_x      (in_ch.win_x),
    .win_y      (in_ch.win_y),
    .win_width  (in_ch.win_width),
    .win_height (in_ch.win_height),
    .pixel_565  (in_ch.pixel_565),
    .red        (in_ch.red),
    .green      (in_ch.green),
    .blue       (in_ch.blue),
    .rotation   (in_ch.rotation),
    .rec        (rec)
  );

  lwpf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .rec_in    (rec),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .frame     (frame),
    .status    (status)
  );

  assign out_ch.frame_prefix = frame.prefix;
  assign out_ch.frame_high   = frame.high;
  assign out_ch.frame_low    = frame.low;
  assign out_ch.last_frame   = frame.last;

  // a new item only enters once the held one has sent its final frame
  a_ready_only_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready && status.busy |-> status.at_last)
    else $error("input ready while item record still has frames to send");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> status.idx <= LAST_IDX_WIN)
    else $error("frame index beyond the last window frame");

  a_take_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> status.busy && status.idx == '0)
    else $error("accepted item did not start at its first frame");

  a_frame_after_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !$past(out_ch.valid) |-> $past(status.busy))
    else $error("frame appeared without a held item record");

endmodule

[tb/sv/lcd_window_and_pixel_formatter_unit_tb.sv]
// Testbench for lcd_window_and_pixel_formatter_unit: a directed table, then random
// window, pixel and rotation items, each frame checked against an in-bench predictor.
// Depends on lwpf_pkg, lwpf_in_if, lwpf_out_if and the formatter top level.
module lcd_window_and_pixel_formatter_unit_tb;
  import lwpf_pkg::*;

  typedef struct packed {
    op_t        op;
    logic [8:0] x;
    logic [8:0] y;
    logic [8:0] w;
    logic [8:0] h;
    logic [15:0] pix;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [1:0] rot;
  } lcd_item_t;

  // typed rows carry the key values by hand: window x0,x1,y0,y1, pixel color,
  // or orientation byte
  typedef struct {
    lcd_item_t   it;
    bit          typed;
    logic [15:0] want [4];
  } stim_row_t;

  logic clk;
  logic rst_n;

  lwpf_in_if  in_ch ();
  lwpf_out_if out_ch ();

  lcd_window_and_pixel_formatter_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_t    frames_due [$];
  stim_row_t dir_rows [$];
  bit        portrait;
  bit        quiet;
  bit        hold_req;
  int        mismatches;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic stim_row_t win_row(int x, int y, int w, int h, bit typed,
                                        int x0, int x1, int y0, int y1);
    stim_row_t row;
    row.it = '0;
    row.it.op = OP_WINDOW;
    row.it.x = 9'(x);
    row.it.y = 9'(y);
    row.it.w = 9'(w);
    row.it.h = 9'(h);
    row.typed = typed;
    row.want = '{16'(x0), 16'(x1), 16'(y0), 16'(y1)};
    return row;
  endfunction

  function automatic stim_row_t raw_row(int pix, bit typed);
    stim_row_t row;
    row.it = '0;
    row.it.op = OP_RAW;
    row.it.pix = 16'(pix);
    row.typed = typed;
    row.want = '{16'(pix), 16'h0, 16'h0, 16'h0};
    return row;
  endfunction

  function automatic stim_row_t rgb_row(int r, int g, int b, int col);
    stim_row_t row;
    row.it = '0;
    row.it.op = OP_RGB;
    row.it.r = 8'(r);
    row.it.g = 8'(g);
    row.it.b = 8'(b);
    row.typed = 1'b1;
    row.want = '{16'(col), 16'h0, 16'h0, 16'h0};
    return row;
  endfunction

  function automatic stim_row_t rot_row(int rot, logic [7:0] ob);
    stim_row_t row;
    row.it = '0;
    row.it.op = OP_ROT;
    row.it.rot = 2'(rot);
    row.typed = 1'b1;
    row.want = '{16'(ob), 16'h0, 16'h0, 16'h0};
    return row;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t row;
    int sel;
    row.typed = 1'b0;
    row.want = '{16'h0, 16'h0, 16'h0, 16'h0};
    // unused fields stay random as noise
    row.it.x   = 9'($urandom_range(0, 511));
    row.it.y   = 9'($urandom_range(0, 511));
    row.it.w   = 9'($urandom_range(0, 511));
    row.it.h   = 9'($urandom_range(0, 511));
    row.it.pix = 16'($urandom_range(0, 65535));
    row.it.r   = 8'($urandom_range(0, 255));
    row.it.g   = 8'($urandom_range(0, 255));
    row.it.b   = 8'($urandom_range(0, 255));
    row.it.rot = 2'($urandom_range(0, 3));
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      row.it.op = OP_RAW;
    end else if (sel < 70) begin
      row.it.op = OP_RGB;
    end else if (sel < 90) begin
      row.it.op = OP_WINDOW;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        row.it.x = 9'($urandom_range(0, 479));
        row.it.y = 9'($urandom_range(0, 479));
        row.it.w = 9'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 480));
        row.it.h = 9'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 480));
      end else if (sel < 8) begin
        // near the right and bottom edges, and past them
        row.it.x = 9'($urandom_range(300, 511));
        row.it.y = 9'($urandom_range(280, 511));
        row.it.w = 9'($urandom_range(0, 80));
        row.it.h = 9'($urandom_range(0, 80));
      end
    end else begin
      row.it.op = OP_ROT;
    end
    return row;
  endfunction

  function automatic void due(logic [7:0] pfx, logic [7:0] hi, logic [7:0] lo, bit fin);
    frame_t f;
    f.prefix = pfx;
    f.high   = hi;
    f.low    = lo;
    f.last   = fin;
    frames_due.push_back(f);
  endfunction

  // Predicts the frames of one accepted item and tracks the orientation
  function automatic void expect_item(stim_row_t row);
    int sw, sh, x, y, w, h, yt;
    logic [15:0] k [4];
    k = '{16'h0, 16'h0, 16'h0, 16'h0};
    case (row.it.op)
      OP_WINDOW: begin
        sw = portrait ? LWPF_SHORT_SIDE : LWPF_LONG_SIDE;
        sh = portrait ? LWPF_LONG_SIDE : LWPF_SHORT_SIDE;
        x = row.it.x;
        y = row.it.y;
        w = row.it.w;
        h = row.it.h;
        if (x > sw - 1) x = sw - 1;
        if (y > sh - 1) y = sh - 1;
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        yt = sh - y - h;   // bottom-left origin to top-left
        k = '{16'(x), 16'(x + w - 1), 16'(yt), 16'(yt + h - 1)};
      end
      OP_RAW: k[0] = row.it.pix;
      OP_RGB: k[0] = {row.it.r[7:3], row.it.g[7:2], row.it.b[7:3]};
      default: begin
        case (row.it.rot)
          2'd0:    k[0] = 16'(ORIENT_0);
          2'd1:    k[0] = 16'(ORIENT_90);
          2'd2:    k[0] = 16'(ORIENT_180);
          default: k[0] = 16'(ORIENT_270);
        endcase
        portrait = row.it.rot[0];
      end
    endcase
    if (row.typed) k = row.want;
    case (row.it.op)
      OP_WINDOW: begin
        due(PFX_CMD, 8'h00, CMD_COL_SET, 1'b0);
        for (int i = 0; i < 4; i++) begin
          if (i == 2) due(PFX_CMD, 8'h00, CMD_PAG_SET, 1'b0);
          due(PFX_DAT, 8'h00, k[i][15:8], 1'b0);
          due(PFX_DAT, 8'h00, k[i][7:0], 1'b0);
        end
        due(PFX_CMD, 8'h00, CMD_MEM_WR, 1'b1);
      end
      OP_ROT: begin
        due(PFX_CMD, 8'h00, CMD_MADCTL, 1'b0);
        due(PFX_DAT, 8'h00, k[0][7:0], 1'b1);
      end
      default: due(PFX_DAT, k[0][15:8], k[0][7:0], 1'b1);
    endcase
  endfunction

  // Entered and left at a falling edge
  task automatic offer_item(stim_row_t row);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= row.it.op;
    in_ch.win_x      <= row.it.x;
    in_ch.win_y      <= row.it.y;
    in_ch.win_width  <= row.it.w;
    in_ch.win_height <= row.it.h;
    in_ch.pixel_565  <= row.it.pix;
    in_ch.red        <= row.it.r;
    in_ch.green      <= row.it.g;
    in_ch.blue       <= row.it.b;
    in_ch.rotation   <= row.it.rot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expect_item(row);
    @(negedge clk);
  endtask

  function automatic void cmp_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : frame_check
    frame_t f;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame, expected none, got %h %h %h %b", $time,
                 out_ch.frame_prefix, out_ch.frame_high, out_ch.frame_low,
                 out_ch.last_frame);
        mismatches++;
      end else begin
        f = frames_due.pop_front();
        cmp_field("prefix", f.prefix, out_ch.frame_prefix);
        cmp_field("high", f.high, out_ch.frame_high);
        cmp_field("low", f.low, out_ch.frame_low);
        cmp_field("last", 8'(f.last), 8'(out_ch.last_frame));
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request
  initial begin : frame_sink
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    portrait = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_WINDOW;
    in_ch.win_x = '0;
    in_ch.win_y = '0;
    in_ch.win_width = '0;
    in_ch.win_height = '0;
    in_ch.pixel_565 = '0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    in_ch.rotation = '0;

    // landscape after reset: 480 wide, 320 tall
    dir_rows.push_back(win_row(0, 0, 1, 1, 1, 0, 0, 319, 319));
    dir_rows.push_back(win_row(0, 0, 480, 480, 1, 0, 479, 0, 319));
    dir_rows.push_back(win_row(511, 511, 511, 511, 1, 479, 479, 0, 0));  // origin off screen
    dir_rows.push_back(win_row(100, 50, 0, 0, 1, 100, 100, 269, 269));   // zero size
    dir_rows.push_back(win_row(479, 319, 1, 1, 1, 479, 479, 0, 0));
    dir_rows.push_back(raw_row(16'h0000, 1));
    dir_rows.push_back(raw_row(16'hFFFF, 1));
    dir_rows.push_back(raw_row(16'hA55A, 1));
    dir_rows.push_back(rgb_row(255, 255, 255, 16'hFFFF));
    dir_rows.push_back(rgb_row(0, 0, 0, 16'h0000));
    dir_rows.push_back(rgb_row(8'hF8, 0, 0, 16'hF800));
    dir_rows.push_back(rgb_row(8'h07, 8'h03, 8'h07, 16'h0000));
    dir_rows.push_back(rgb_row(0, 8'hFC, 0, 16'h07E0));
    dir_rows.push_back(rgb_row(0, 0, 8'hF8, 16'h001F));
    dir_rows.push_back(rot_row(1, ORIENT_90));
    // portrait: 320 wide, 480 tall
    dir_rows.push_back(win_row(0, 0, 480, 480, 1, 0, 319, 0, 479));
    dir_rows.push_back(win_row(400, 479, 5, 5, 1, 319, 319, 0, 0));
    dir_rows.push_back(win_row(10, 20, 30, 40, 0, 0, 0, 0, 0));
    dir_rows.push_back(rot_row(2, ORIENT_180));
    dir_rows.push_back(win_row(300, 200, 100, 100, 0, 0, 0, 0, 0));
    dir_rows.push_back(rot_row(3, ORIENT_270));
    dir_rows.push_back(win_row(5, 5, 0, 480, 0, 0, 0, 0, 0));
    dir_rows.push_back(rot_row(0, ORIENT_0));
    dir_rows.push_back(raw_row(16'h1234, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer_item(dir_rows[i]);

    for (int n = 0; n < 410; n++) begin
      if (n == 100) quiet = 1'b1;
      if (n == 200) quiet = 1'b0;
      if (n == 300) hold_req = 1'b1;
      offer_item(rand_row());
    end
    in_ch.valid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
